// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the hash engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/mm3_pkg.sv =====
// Types, constants and helper functions for the MurmurHash3 engine.
`default_nettype none
package mm3_pkg;

    localparam logic [31:0] C1      = 32'hcc9e2d51;
    localparam logic [31:0] C2      = 32'h1b873593;
    localparam logic [31:0] ADD_C   = 32'he6546b64;
    localparam logic [31:0] F1      = 32'h85ebca6b;
    localparam logic [31:0] F2      = 32'hc2b2ae35;
    localparam logic [2:0]  FULL_VB = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCRAMBLE,
        ST_FOLD,
        ST_FMIX1,
        ST_FMIX2,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCRAMBLE,
        OP_FOLD,
        OP_FMIX1,
        OP_FMIX2,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_busy;
    } status_t;

    function automatic logic [31:0] rotl15(input logic [31:0] x);
        return {x[16:0], x[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] x);
        return {x[18:0], x[31:19]};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mm3_datapath.sv =====
// Datapath of the hash engine: hash, key and length registers and one shared multiplier.
`default_nettype none
`include "assert_macros.svh"
module mm3_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mm3_pkg::cmd_t cmd,
    output mm3_pkg::status_t   status,
    input  wire logic          cfg_valid,
    input  wire logic [31:0]   seed_value,
    input  wire logic [31:0]   data_word,
    input  wire logic [2:0]    valid_bytes,
    input  wire logic          last_word,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [31:0]        hash_value
);
    import mm3_pkg::*;

    logic [31:0] seed_reg;
    logic [31:0] h_reg, h_next;
    logic [31:0] k_reg, k_next;
    logic [31:0] len_reg, len_next;
    logic [2:0]  vb_reg, vb_next;
    logic        last_reg, last_next;
    logic        in_msg_reg, in_msg_next;
    logic [31:0] hash_reg, hash_next;
    logic        out_valid_reg, out_valid_next;

    logic [2:0]  vb_sat;
    logic [31:0] word_masked;
    logic [31:0] mul_a, mul_b, product;
    logic [31:0] mix_t, fold_r;

    // Words before the last always count as four bytes.
    always_comb
    begin
        if (!last_word || valid_bytes > FULL_VB)
            vb_sat = FULL_VB;
        else
            vb_sat = valid_bytes;
        case (vb_sat)
            3'd0:    word_masked = 32'h0;
            3'd1:    word_masked = {24'h0, data_word[7:0]};
            3'd2:    word_masked = {16'h0, data_word[15:0]};
            3'd3:    word_masked = {8'h0, data_word[23:0]};
            default: word_masked = data_word;
        endcase
    end

    assign mix_t  = h_reg ^ len_reg;
    assign fold_r = rotl13(h_reg ^ k_reg);

    always_comb
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                mul_a = word_masked;
                mul_b = C1;
            end
            OP_SCRAMBLE:
            begin
                mul_a = rotl15(k_reg);
                mul_b = C2;
            end
            OP_FMIX1:
            begin
                mul_a = mix_t ^ {16'h0, mix_t[31:16]};
                mul_b = F1;
            end
            OP_FMIX2:
            begin
                mul_a = h_reg ^ {13'h0, h_reg[31:13]};
                mul_b = F2;
            end
            default:
            begin
                mul_a = 32'h0;
                mul_b = 32'h0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    always_comb
    begin
        h_next         = h_reg;
        k_next         = k_reg;
        len_next       = len_reg;
        vb_next        = vb_reg;
        last_next      = last_reg;
        in_msg_next    = in_msg_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (cmd.op)
            OP_LOAD:
            begin
                k_next      = product;
                vb_next     = vb_sat;
                last_next   = last_word;
                in_msg_next = 1'b1;
                if (!in_msg_reg)
                begin
                    h_next   = seed_reg;
                    len_next = 32'h0;
                end
            end
            OP_SCRAMBLE:
                k_next = product;
            OP_FOLD:
            begin
                if (vb_reg == FULL_VB)
                    h_next = {fold_r[29:0], 2'b00} + fold_r + ADD_C;
                else if (vb_reg != 3'd0)
                    h_next = h_reg ^ k_reg;
                len_next = len_reg + {29'h0, vb_reg};
            end
            OP_FMIX1, OP_FMIX2:
                h_next = product;
            OP_FINISH:
            begin
                hash_next      = h_reg ^ {16'h0, h_reg[31:16]};
                out_valid_next = 1'b1;
                in_msg_next    = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= 32'h0;
            in_msg_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                seed_reg <= seed_value;
            in_msg_reg    <= in_msg_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg    <= h_next;
        k_reg    <= k_next;
        len_reg  <= len_next;
        vb_reg   <= vb_next;
        hash_reg <= hash_next;
    end

    assign status.last     = last_reg;
    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign hash_value      = hash_reg;

    `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, cmd.op == OP_FINISH, !out_valid_reg || out_ready)
    `ASSERT_NEXT(a_load_opens, clk, rst_n, cmd.op == OP_LOAD, in_msg_reg && vb_reg <= FULL_VB)
    `ASSERT_NEXT(a_finish_closes, clk, rst_n, cmd.op == OP_FINISH, out_valid_reg && !in_msg_reg)

endmodule
`default_nettype wire

// ===== rtl/core/mm3_ctrl.sv =====
// Sequencer of the hash engine: scrambles and folds each item, finalises the last.
`default_nettype none
`include "assert_macros.svh"
module mm3_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire mm3_pkg::status_t status,
    output mm3_pkg::cmd_t         cmd
);
    import mm3_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_SCRAMBLE;
            ST_SCRAMBLE:
                state_next = ST_FOLD;
            ST_FOLD:
                state_next = status.last ? ST_FMIX1 : ST_IDLE;
            ST_FMIX1:
                state_next = ST_FMIX2;
            ST_FMIX2:
                state_next = ST_FINISH;
            ST_FINISH:
                if (!status.out_busy)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = OP_LOAD;
            end
            ST_SCRAMBLE:
                cmd.op = OP_SCRAMBLE;
            ST_FOLD:
                cmd.op = OP_FOLD;
            ST_FMIX1:
                cmd.op = OP_FMIX1;
            ST_FMIX2:
                cmd.op = OP_FMIX2;
            ST_FINISH:
                // The result register must be free before a new hash is written.
                if (!status.out_busy)
                    cmd.op = OP_FINISH;
            default:
                cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    `ASSERT_NEXT(a_accept_scrambles, clk, rst_n, in_valid && in_ready, state_reg == ST_SCRAMBLE)
    `ASSERT_NEXT(a_word_returns, clk, rst_n, state_reg == ST_FOLD && !status.last, state_reg == ST_IDLE)
    `ASSERT_IMPLIES(a_ready_idle, clk, rst_n, in_ready, cmd.op == OP_LOAD || !in_valid)

endmodule
`default_nettype wire

// ===== rtl/core/murmur3_32_hash.sv =====
// MurmurHash3 x86_32 engine: top level joining the sequencer and the datapath.
//
// Input channel (in_valid/in_ready): one item carries data_word (little-endian
// message bytes), valid_bytes and last_word. Every item before the last counts
// as four bytes; on the last item valid_bytes (0 to 4, larger values taken as 4)
// gives the bytes that count.
// Output channel (out_valid/out_ready): one hash_value per message, held in an
// output register until taken.
// Configuration channel (cfg_valid/cfg_ready): writes the seed, always ready;
// the seed is sampled at the first item of each message.
// Each item is accepted with the first multiply, then takes the second multiply
// and the fold, and no new item is taken before the fold; a last item then takes
// the two finaliser multiplies and a finish step that loads the output register.
// One shared 32-bit multiplier serves twice per word and twice in the finaliser.
// If the receiver stalls, the engine keeps accepting items until a second hash
// is ready, then waits in its final step until the first one is taken.
// Reset clears the seed to zero and abandons any partly hashed message.
`default_nettype none
module murmur3_32_hash (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] seed_value,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  valid_bytes,
    input  wire logic        last_word,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      hash_value
);
    import mm3_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    mm3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mm3_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .seed_value  (seed_value),
        .data_word   (data_word),
        .valid_bytes (valid_bytes),
        .last_word   (last_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hash_value  (hash_value)
    );

endmodule
`default_nettype wire

// ===== sim/tb_murmur3_32_hash.sv =====
// Self-checking testbench for the MurmurHash3 x86_32 engine murmur3_32_hash.
module tb_murmur3_32_hash;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

    localparam int DRAIN_CYCLES     = 16;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS      = 150;
    localparam int NUM_PHASES       = 7;
    localparam int DIR_ROWS         = 23;

    typedef enum logic {ROW_ITEM, ROW_SEED} row_kind_t;
    typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE, RX_BURSTY} rx_mode_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
        logic        typed;
        logic [31:0] hash;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] seed_value;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] hash_value;

    murmur3_32_hash u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .seed_value (seed_value),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_word  (data_word),
        .valid_bytes(valid_bytes),
        .last_word  (last_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

    logic [31:0] hash_q [$];
    dir_row_t    dir_tbl [0:DIR_ROWS-1];
    int          err_count;
    int          burst_left;
    int          phase_items;
    logic        long_hold_req;
    logic [31:0] exp_hash;

    // Predicted engine state.
    logic [31:0] mdl_seed;
    logic [31:0] mdl_hash;
    logic [31:0] mdl_len;
    logic        mdl_open;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] scramble_word(input logic [31:0] k);
        logic [31:0] t;
        t = k * MIX_C1;
        t = rotl(t, 15);
        return t * MIX_C2;
    endfunction

    function automatic logic [31:0] fold_word(input logic [31:0] h, input logic [31:0] w);
        logic [31:0] t;
        t = rotl(h ^ scramble_word(w), 13);
        return t * 32'd5 + MIX_ADD;
    endfunction

    function automatic logic [31:0] finalise(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * FIN_M1;
        t = t ^ (t >> 13);
        t = t * FIN_M2;
        return t ^ (t >> 16);
    endfunction

    // Advances the predicted state by one accepted item and reports a digest at message end.
    task automatic predict_item(input logic [31:0] word, input logic [2:0] nbytes,
                                input logic last, output logic got,
                                output logic [31:0] digest);
        logic [2:0]  nb;
        logic [31:0] h;
        if (!mdl_open) begin
            mdl_hash = mdl_seed;
            mdl_len  = 32'd0;
            mdl_open = 1'b1;
        end
        got    = 1'b0;
        digest = 32'd0;
        if (!last) begin
            mdl_hash = fold_word(mdl_hash, word);
            mdl_len  = mdl_len + 32'd4;
        end else begin
            nb = (nbytes > 3'd4) ? 3'd4 : nbytes;
            h  = mdl_hash;
            if (nb == 3'd4)
                h = fold_word(h, word);
            else if (nb != 3'd0)
                h = h ^ scramble_word(word & ((32'd1 << (8 * nb)) - 32'd1));
            mdl_len  = mdl_len + 32'(nb);
            digest   = finalise(h ^ mdl_len);
            got      = 1'b1;
            mdl_hash = mdl_seed;
            mdl_len  = 32'd0;
            mdl_open = 1'b0;
        end
    endtask

    task automatic send_item(input logic [31:0] word, input logic [2:0] nbytes,
                             input logic last, input logic typed,
                             input logic [31:0] typed_hash);
        logic        got;
        logic [31:0] digest;
        in_valid    <= 1'b1;
        data_word   <= word;
        valid_bytes <= nbytes;
        last_word   <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_item(word, nbytes, last, got, digest);
        if (got)
            hash_q.push_back(typed ? typed_hash : digest);
    endtask

    // Bursts of back-to-back items separated by short random gaps.
    task automatic pace_sender();
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (hash_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        cfg_valid  <= 1'b1;
        seed_value <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        mdl_seed = value;
    endtask

    task automatic send_message(input bit paced);
        int          len;
        int          pick;
        logic [31:0] w;
        logic [2:0]  nb;
        logic        last;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            len = $urandom_range(1, 8);
        else if (pick < 95)
            len = $urandom_range(9, 24);
        else
            len = $urandom_range(25, 64);
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                w = 32'h0;
            else if (pick == 1)
                w = 32'hffffffff;
            else
                w = $urandom;
            last = (i == len - 1);
            if (last && $urandom_range(0, 9) < 4)
                nb = 3'd4;
            else
                nb = 3'($urandom_range(0, 7));
            if (paced)
                pace_sender();
            send_item(w, nb, last, 1'b0, 32'h0);
            phase_items++;
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        seed_value  <= 32'h0;
        in_valid    <= 1'b0;
        data_word   <= 32'h0;
        valid_bytes <= 3'd0;
        last_word   <= 1'b0;
        err_count     = 0;
        burst_left    = 0;
        phase_items   = 0;
        long_hold_req = 1'b0;
        mdl_seed      = 32'h0;
        mdl_hash      = 32'h0;
        mdl_len       = 32'h0;
        mdl_open      = 1'b0;
        // The empty message just after reset hashes the zero seed to zero.
        dir_tbl = '{
            '{ROW_ITEM, 32'h00000000, 3'd0, 1'b1, 1'b1, 32'h00000000},
            '{ROW_ITEM, 32'hffffffff, 3'd4, 1'b1, 1'b0, 32'h0},
            '{ROW_ITEM, 32'hffffffff, 3'd1, 1'b1, 1'b0, 32'h0},
            '{ROW_ITEM, 32'hffffffff, 3'd2, 1'b1, 1'b0, 32'h0},
            '{ROW_ITEM, 32'hffffffff, 3'd3, 1'b1, 1'b0, 32'h0},
            '{ROW_ITEM, 32'h00000000, 3'd4, 1'b1, 1'b0, 32'h0},
            '{ROW_ITEM, 32'h12345678, 3'd7, 1'b1, 1'b0, 32'h0},
            '{ROW_ITEM, 32'h87654321, 3'd5, 1'b1, 1'b0, 32'h0},
            '{ROW_SEED, 32'hffffffff, 3'd0, 1'b0, 1'b0, 32'h0},
            '{ROW_ITEM, 32'h00000000, 3'd0, 1'b1, 1'b0, 32'h0},
            '{ROW_ITEM, 32'ha5a5a5a5, 3'd0, 1'b0, 1'b0, 32'h0},
            '{ROW_ITEM, 32'h5a5a5a5a, 3'd3, 1'b0, 1'b0, 32'h0},
            '{ROW_ITEM, 32'hdeadbeef, 3'd6, 1'b0, 1'b0, 32'h0},
            '{ROW_ITEM, 32'hffffffff, 3'd2, 1'b1, 1'b0, 32'h0},
            '{ROW_SEED, 32'h9747b28c, 3'd0, 1'b0, 1'b0, 32'h0},
            '{ROW_ITEM, 32'h00000000, 3'd4, 1'b0, 1'b0, 32'h0},
            '{ROW_ITEM, 32'hffffffff, 3'd0, 1'b1, 1'b0, 32'h0},
            '{ROW_ITEM, 32'h80000001, 3'd7, 1'b0, 1'b0, 32'h0},
            '{ROW_ITEM, 32'h00000000, 3'd4, 1'b1, 1'b0, 32'h0},
            '{ROW_SEED, 32'h00000000, 3'd0, 1'b0, 1'b0, 32'h0},
            '{ROW_ITEM, 32'h01020304, 3'd1, 1'b0, 1'b0, 32'h0},
            '{ROW_ITEM, 32'h00000000, 3'd0, 1'b1, 1'b0, 32'h0},
            '{ROW_ITEM, 32'h7fffffff, 3'd6, 1'b1, 1'b0, 32'h0}
        };
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tbl[i]) begin
            if (dir_tbl[i].kind == ROW_SEED) begin
                drain_results();
                write_seed(dir_tbl[i].word);
            end else begin
                pace_sender();
                send_item(dir_tbl[i].word, dir_tbl[i].nbytes, dir_tbl[i].last,
                          dir_tbl[i].typed, dir_tbl[i].hash);
            end
        end

        // Each phase starts from an idle engine with a fresh seed; phase 3 sends flat out.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            case (ph)
                0:       write_seed(32'h00000000);
                1:       write_seed(32'hffffffff);
                2:       write_seed(32'h00000001);
                default: write_seed($urandom);
            endcase
            if (ph == 1)
                long_hold_req = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                send_message(ph != 3);
        end

        drain_results();
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // The receiver switches between stall patterns and honours one long hold-off.
    initial begin
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        int       tick;
        out_ready <= 1'b0;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        forever begin
            @(posedge clk);
            tick++;
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
                    default:   out_ready <= tick[2];
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (hash_q.size() == 0) begin
                err_count++;
                $display("%0t: hash_value expected none, actual %h", $time, hash_value);
            end else begin
                exp_hash = hash_q.pop_front();
                if (hash_value !== exp_hash) begin
                    err_count++;
                    $display("%0t: hash_value expected %h, actual %h",
                             $time, exp_hash, hash_value);
                end
            end
        end
    end

    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mm3_pkg.sv
rtl/core/mm3_datapath.sv
rtl/core/mm3_ctrl.sv
rtl/core/murmur3_32_hash.sv
sim/tb_murmur3_32_hash.sv
